// ----- hdl/hbsf_pkg.sv -----
// shared types and constants for the half/bf16/single converter
package hbsf_pkg;

  typedef enum logic [1:0] {
    OP_H2S = 2'd0,
    OP_B2S = 2'd1,
    OP_S2H = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [31:0] F32_INF = 32'h7F80_0000;
  localparam logic [31:0] F16_MAX_AS32 = 32'h477F_E000;
  localparam logic [31:0] F16_MIN_AS32 = 32'h3880_0000;
  localparam logic [7:0] BIAS_DIFF = 8'd112;

  // stage 1 to stage 2 item
  typedef struct packed {
    op_t op;
    logic [31:0] bits;
    logic sgn;
    logic [1:0] cls;
    logic [3:0] lz;
  } s1_t;

  localparam logic [1:0] CLS_PLAIN = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_SPECIAL = 2'd2;
  localparam logic [1:0] CLS_OVER = 2'd3;

endpackage

// ----- hdl/hbsf_classify.sv -----
// first stage: decode, leading-zero count and range compares
module hbsf_classify (
  input  logic [1:0]  op,
  input  logic [31:0] operand_bits,
  output hbsf_pkg::s1_t item
);

  logic [9:0] man;
  logic [4:0] ex;
  logic [30:0] a;
  logic [3:0] lz;

  always_comb begin
    man = operand_bits[9:0];
    ex = operand_bits[14:10];
    a = operand_bits[30:0];
    lz = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) lz = 4'(10 - i);
    end
    item.op = hbsf_pkg::op_t'(op);
    item.bits = operand_bits;
    item.lz = lz;
    item.sgn = 1'b0;
    item.cls = hbsf_pkg::CLS_PLAIN;
    unique case (hbsf_pkg::op_t'(op))
      hbsf_pkg::OP_H2S: begin
        item.sgn = operand_bits[15];
        if (ex == 5'd31) item.cls = hbsf_pkg::CLS_SPECIAL;
        else if (ex == 5'd0 && man == 10'd0) item.cls = hbsf_pkg::CLS_ZERO;
      end
      hbsf_pkg::OP_S2H: begin
        item.sgn = operand_bits[31];
        if ({1'b0, a} < hbsf_pkg::F16_MIN_AS32) item.cls = hbsf_pkg::CLS_ZERO;
        else if ({1'b0, a} > hbsf_pkg::F32_INF) item.cls = hbsf_pkg::CLS_SPECIAL;
        else if ({1'b0, a} > hbsf_pkg::F16_MAX_AS32) item.cls = hbsf_pkg::CLS_OVER;
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/hbsf_convert.sv -----
// second stage: shifts and exponent rebias producing the result pattern
module hbsf_convert (
  input  hbsf_pkg::s1_t item,
  output logic [31:0]   result
);

  logic [9:0] man;
  logic [10:0] nman;
  logic [9:0] frac;
  logic [7:0] e32;
  logic [7:0] e;
  logic [7:0] sh;
  logic [23:0] sig;
  logic [23:0] sub;
  logic [9:0] nanm;
  logic [15:0] h;
  logic [15:0] v;

  always_comb begin
    man = item.bits[9:0];
    nman = {1'b0, man} << item.lz;
    if (item.bits[14:10] == 5'd0) begin
      e32 = 8'(8'd1 - {4'd0, item.lz} + hbsf_pkg::BIAS_DIFF);
      frac = nman[9:0];
    end else begin
      e32 = 8'({3'd0, item.bits[14:10]} + hbsf_pkg::BIAS_DIFF);
      frac = man;
    end
    e = item.bits[30:23];
    sh = 8'(8'd126 - e);
    sig = {1'b1, item.bits[22:0]};
    sub = (sh >= 8'd32) ? 24'd0 : (sig >> sh[4:0]);
    nanm = (item.bits[22:13] == 10'd0) ? 10'd1 : item.bits[22:13];
    v = 16'(item.bits[30:13] - 18'(hbsf_pkg::BIAS_DIFF) * 18'd1024);
    h = 16'd0;
    result = 32'd0;
    unique case (item.op)
      hbsf_pkg::OP_H2S: begin
        unique case (item.cls)
          hbsf_pkg::CLS_SPECIAL: result = {item.sgn, 8'hFF, man, 13'd0};
          hbsf_pkg::CLS_ZERO: result = {item.sgn, 31'd0};
          default: result = {item.sgn, e32, frac, 13'd0};
        endcase
      end
      hbsf_pkg::OP_B2S: result = {item.bits[15:0], 16'd0};
      hbsf_pkg::OP_S2H: begin
        unique case (item.cls)
          hbsf_pkg::CLS_ZERO:
            h = (e == 8'd0) ? {item.sgn, 15'd0} : {item.sgn, sub[14:0]};
          hbsf_pkg::CLS_SPECIAL: h = {item.sgn, 5'h1F, nanm};
          hbsf_pkg::CLS_OVER: h = {item.sgn, 15'h7C00};
          default: h = {item.sgn, v[14:0]};
        endcase
        result = {16'd0, h};
      end
      default: result = 32'd0;
    endcase
  end

endmodule

// ----- hdl/half_bf16_single_float_converter.sv -----
// top level: three-stage converter between fp16, bf16 and fp32 patterns
// Usage:
//   input channel: in_valid/in_ready carry op and operand_bits; op 0 is
//   fp16 to fp32, 1 bf16 to fp32, 2 fp32 to fp16, 3 gives zero.
//   output channel: out_valid/out_ready carry result_bits, one per input.
//   An item passes from the input registers (op0, bits0) to item1 and then
//   to result_bits, where out_valid shows it. Stage 1 registers the input,
//   stage 2 the decode (leading-zero count, range compares), stage 3 the
//   converted pattern. One item may enter every cycle unless the output
//   stalls; the rate is set by the stage chain, each stage holding one item.
//   A stage advances whenever it is empty or the stage after it moves, so
//   an output stall backs up through the chain without losing or repeating
//   items, and in_ready falls only when all three stages are full and
//   out_ready is low.
//   Reset (rst, synchronous) empties all stages.
module half_bf16_single_float_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_bits
);

  logic v0, v1, v2;
  logic [1:0] op0;
  logic [31:0] bits0;
  hbsf_pkg::s1_t item_next, item1;
  logic [31:0] result_next;
  logic adv0, adv1, adv2;

  assign adv2 = !v2 || out_ready;
  assign adv1 = !v1 || adv2;
  assign adv0 = !v0 || adv1;
  assign in_ready = adv0;
  assign out_valid = v2;

  hbsf_classify u_classify (.op(op0), .operand_bits(bits0), .item(item_next));
  hbsf_convert u_convert (.item(item1), .result(result_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv0) v0 <= in_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
    end
    if (adv0 && in_valid) begin
      op0 <= op;
      bits0 <= operand_bits;
    end
    if (adv1 && v0) item1 <= item_next;
    if (adv2 && v1) result_bits <= result_next;
  end

endmodule

// ----- verif/half_bf16_single_float_converter_tb.sv -----
// testbench for the half/bf16/single converter: random and directed conversions checked in order

class conversion_board;
  logic [31:0] pending[$];
  int errors;

  function logic [31:0] widen_half(logic [15:0] h);
    logic sgn;
    logic [4:0] ex;
    logic [9:0] man;
    logic [10:0] m;
    logic [7:0] e32;
    int k;
    sgn = h[15];
    ex = h[14:10];
    man = h[9:0];
    if (ex == 5'd31) return {sgn, 8'hFF, man, 13'd0};
    if (ex == 5'd0) begin
      if (man == 10'd0) return {sgn, 31'd0};
      m = {1'b0, man};
      k = 0;
      while (!m[10]) begin
        m = m << 1;
        k++;
      end
      e32 = 8'd113 - 8'(k);
      return {sgn, e32, m[9:0], 13'd0};
    end
    e32 = 8'(ex) + 8'd112;
    return {sgn, e32, man, 13'd0};
  endfunction

  function logic [31:0] narrow_single(logic [31:0] x);
    logic [15:0] sgn;
    logic [31:0] a;
    logic [31:0] v;
    int unsigned e;
    int unsigned sh;
    sgn = {x[31], 15'd0};
    a = {1'b0, x[30:0]};
    if (a < 32'h3880_0000) begin
      e = a >> 23;
      if (e == 0) return {16'd0, sgn};
      sh = 126 - e;
      if (sh >= 32) return {16'd0, sgn};
      v = {8'd1, a[22:0]} >> sh;
      return {16'd0, sgn | v[15:0]};
    end
    if (a > 32'h7F80_0000) begin
      v = (a >> 13) & 32'h3FF;
      if (v == 0) v = 1;
      return {16'd0, sgn | 16'h7C00 | v[15:0]};
    end
    if (a > 32'h477F_E000) return {16'd0, sgn | 16'h7C00};
    v = (a >> 13) - (32'd112 << 10);
    return {16'd0, sgn | {1'b0, v[14:0]}};
  endfunction

  function void note_operand(hbsf_pkg::op_t op, logic [31:0] b);
    logic [31:0] r;
    case (op)
      hbsf_pkg::OP_H2S: r = widen_half(b[15:0]);
      hbsf_pkg::OP_B2S: r = {b[15:0], 16'd0};
      hbsf_pkg::OP_S2H: r = narrow_single(b);
      default: r = 32'd0;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(logic [31:0] got);
    logic [31:0] want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (want !== got) begin
      errors++;
      if (errors <= 10) $display("result_bits expected %h actual %h", want, got);
    end
  endfunction
endclass

module half_bf16_single_float_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] op = hbsf_pkg::OP_H2S;
  logic [31:0] operand_bits = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [31:0] result_bits;
  bit calm = 0;
  bit sent_all = 0;
  conversion_board board = new();

  half_bf16_single_float_converter DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  task automatic send(hbsf_pkg::op_t o, logic [31:0] b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    op <= o;
    operand_bits <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_operand(o, b);
  endtask

  function automatic logic [31:0] rand_bits();
    logic [31:0] b;
    logic [31:0] s;
    b = $urandom();
    s = {b[31], 31'd0};
    case ($urandom_range(0, 7))
      0: b = s | 32'h7F80_0000 | ($urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 32'h7F_FFFF));
      1: b = s | $urandom_range(32'h3300_0000, 32'h3880_0000);
      2: b = s | $urandom_range(32'h477F_0000, 32'h4780_2000);
      3: b = s | $urandom_range(0, 32'h7F_FFFF);
      4: b[14:10] = $urandom_range(0, 1) ? 5'd0 : 5'd31;
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    logic [31:0] directed[$];
    hbsf_pkg::op_t o;
    directed = '{32'h0, 32'h8000, 32'h0001, 32'h8001, 32'h03FF, 32'h0200, 32'h7BFF, 32'h7C00,
                 32'hFC00, 32'h7C01, 32'hFE00, 32'hFFFF_3C00, 32'h0000_FFFF};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send(hbsf_pkg::OP_H2S, directed[i]);
    send(hbsf_pkg::OP_B2S, 32'hABCD_FFFF);
    send(hbsf_pkg::OP_B2S, 32'h1234_0000);
    directed = '{32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0001, 32'hFFC0_0000, 32'h477F_E000,
                 32'h477F_E001, 32'h3880_0000, 32'h387F_FFFF, 32'h8000_0001, 32'h3300_0000};
    foreach (directed[i]) send(hbsf_pkg::OP_S2H, directed[i]);
    send(hbsf_pkg::OP_NONE, 32'hFFFF_FFFF);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    for (int n = 0; n < 550; n++) begin
      if (n == 470) calm = 1;
      o = hbsf_pkg::op_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
      send(o, rand_bits());
    end
    in_valid <= 0;
    sent_all = 1;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) board.check_result(result_bits);
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 13);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  initial begin
    wait (sent_all);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #100000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ----- half_bf16_single_float_converter.f -----
hdl/hbsf_pkg.sv
hdl/hbsf_classify.sv
hdl/hbsf_convert.sv
hdl/half_bf16_single_float_converter.sv
verif/half_bf16_single_float_converter_tb.sv
